// ===== rtl/lbns_pkg.sv =====
// Shared types and constants for the LRU block number set.
package lbns_pkg;

	// Default capacity of the set.
	localparam int LBNS_ENTRIES = 64;

	// Payload widths.
	localparam int MODE_W = 2;
	localparam int KEY_W  = 64;

	// Operation codes on the request channel.
	typedef enum logic [MODE_W-1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_TAIL,
		ST_EVICT,
		ST_DONE
	} state_t;

	// Read address selection for the key and link memories.
	typedef enum logic [1:0] {
		RD_NONE,
		RD_HEAD,
		RD_NEXT
	} rd_sel_t;

	// Update performed on the list by the datapath.
	typedef enum logic [2:0] {
		WR_NONE,
		WR_PREV_LINK,
		WR_TAIL_CUR,
		WR_APPEND,
		WR_EVICT
	} wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_key;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    head_adv;
		logic    clear;
	} lbns_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic match;
		logic last;
		logic cur_head;
		logic cur_tail;
	} lbns_sts_t;

endpackage

// ===== rtl/lbns_req_if.sv =====
// Request channel: operation code and block number with valid/ready.
interface lbns_req_if
	import lbns_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [KEY_W-1:0]  block_key;

	modport source (output valid, output mode, output block_key, input ready);
	modport sink   (input valid, input mode, input block_key, output ready);
endinterface

// ===== rtl/lbns_rsp_if.sv =====
// Response channel: hit and eviction flags with valid/ready.
interface lbns_rsp_if
	import lbns_pkg::*;
();
	logic valid;
	logic ready;
	logic hit;
	logic evicted;

	modport source (output valid, output hit, output evicted, input ready);
	modport sink   (input valid, input hit, input evicted, output ready);
endinterface

// ===== rtl/lbns_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lbns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/lbns_dpath.sv =====
// Datapath: key and link memories, list head, tail, count and walk pointers.
module lbns_dpath import lbns_pkg::*; #(
	parameter int ENTRIES = LBNS_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [KEY_W-1:0] in_key,
	input  lbns_cmd_t        cmd,
	output lbns_sts_t        sts
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] prev_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] step_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [KEY_W-1:0] key_rdata;
	logic [IDX_W-1:0] nxt_rdata;

	logic             key_we;
	logic [IDX_W-1:0] key_waddr;
	logic             nxt_we;
	logic [IDX_W-1:0] nxt_waddr;
	logic [IDX_W-1:0] nxt_wdata;
	logic [IDX_W-1:0] append_idx;

	// While the set is not full, the slots in use are exactly 0 to count-1.
	assign append_idx = count_q[IDX_W-1:0];

	// Read address: the oldest entry (walk start or eviction), or the link just read.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		case (cmd.rd_sel)
			RD_HEAD: begin
				rd_en   = 1'b1;
				rd_addr = head_q;
			end
			RD_NEXT: begin
				rd_en   = 1'b1;
				rd_addr = nxt_rdata;
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = head_q;
			end
		endcase
	end

	// Memory writes for each list update.
	always_comb begin
		key_we    = 1'b0;
		key_waddr = append_idx;
		nxt_we    = 1'b0;
		nxt_waddr = tail_q;
		nxt_wdata = cur_q;
		case (cmd.wr_sel)
			WR_PREV_LINK: begin
				nxt_we    = 1'b1;
				nxt_waddr = prev_q;
				nxt_wdata = nxt_rdata;
			end
			WR_TAIL_CUR: begin
				nxt_we    = 1'b1;
				nxt_waddr = tail_q;
				nxt_wdata = cur_q;
			end
			WR_APPEND: begin
				key_we    = 1'b1;
				key_waddr = append_idx;
				nxt_we    = (count_q != '0);
				nxt_waddr = tail_q;
				nxt_wdata = append_idx;
			end
			WR_EVICT: begin
				key_we    = 1'b1;
				key_waddr = head_q;
				nxt_we    = 1'b1;
				nxt_waddr = tail_q;
				nxt_wdata = head_q;
			end
			default: begin
				key_we = 1'b0;
				nxt_we = 1'b0;
			end
		endcase
	end

	lbns_ram #(
		.WIDTH (KEY_W),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	lbns_ram #(
		.WIDTH (IDX_W),
		.DEPTH (ENTRIES)
	) u_link_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (nxt_rdata)
	);

	// Request key register.
	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= in_key;
		end
	end

	// List pointers, fill count and walk position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			cur_q   <= '0;
			prev_q  <= '0;
			count_q <= '0;
			step_q  <= '0;
		end else begin
			case (cmd.rd_sel)
				RD_HEAD: begin
					cur_q  <= head_q;
					step_q <= '0;
				end
				RD_NEXT: begin
					cur_q  <= nxt_rdata;
					prev_q <= cur_q;
					step_q <= step_q + CNT_W'(1);
				end
				default: begin
					cur_q <= cur_q;
				end
			endcase

			case (cmd.wr_sel)
				WR_TAIL_CUR: begin
					tail_q <= cur_q;
				end
				WR_APPEND: begin
					tail_q  <= append_idx;
					count_q <= count_q + CNT_W'(1);
					if (count_q == '0) begin
						head_q <= append_idx;
					end
				end
				WR_EVICT: begin
					tail_q <= head_q;
					head_q <= nxt_rdata;
				end
				default: begin
					tail_q <= tail_q;
				end
			endcase

			if (cmd.head_adv) begin
				head_q <= nxt_rdata;
			end

			if (cmd.clear) begin
				count_q <= '0;
			end
		end
	end

	// Status back to the controller.
	always_comb begin
		sts.empty    = (count_q == '0);
		sts.full     = (count_q == CNT_W'(ENTRIES));
		sts.match    = (key_rdata == key_q);
		sts.last     = ((step_q + CNT_W'(1)) == count_q);
		sts.cur_head = (cur_q == head_q);
		sts.cur_tail = (cur_q == tail_q);
	end

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count above capacity");

	// A walk never steps past the newest entry.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_sel == RD_NEXT) |-> ((step_q + CNT_W'(1)) < count_q))
		else $error("walk past end of list");

	// Appends happen only with room left, evictions only when full.
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_sel == WR_APPEND) |-> (count_q < CNT_W'(ENTRIES)))
		else $error("append into full set");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_sel == WR_EVICT) |-> (count_q == CNT_W'(ENTRIES)))
		else $error("eviction from set that is not full");

endmodule

// ===== rtl/lbns_ctrl.sv =====
// Controller: sequences list operations and holds the response output register.
module lbns_ctrl import lbns_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] in_mode,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_hit,
	output logic              out_evicted,
	output lbns_cmd_t         cmd,
	input  lbns_sts_t         sts
);

	state_t            state_q;
	state_t            state_d;
	logic [MODE_W-1:0] mode_q;
	logic              res_hit_q;
	logic              res_evicted_q;
	logic              out_valid_q;
	logic              out_hit_q;
	logic              out_evicted_q;

	logic              accept;
	logic              slot_free;
	logic              res_load;
	logic              res_hit;
	logic              res_evicted;

	// The output register can take a result when empty or being drained.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) || ((state_q == ST_DONE) && slot_free);
	assign accept    = in_valid && in_ready;

	assign out_valid   = out_valid_q;
	assign out_hit     = out_hit_q;
	assign out_evicted = out_evicted_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (mode_q)
					MODE_LOOKUP: state_d = sts.empty ? ST_DONE : ST_WALK;
					MODE_ADD:    state_d = sts.full ? ST_EVICT : ST_DONE;
					default:     state_d = ST_DONE;
				endcase
			end
			ST_WALK: begin
				if (sts.match) begin
					state_d = (sts.cur_tail || sts.cur_head) ? ST_DONE : ST_TAIL;
				end else if (sts.last) begin
					state_d = ST_DONE;
				end
			end
			ST_TAIL: begin
				state_d = ST_DONE;
			end
			ST_EVICT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = accept ? ST_EXEC : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands and result for each state.
	always_comb begin
		cmd.load_key = accept;
		cmd.rd_sel   = RD_NONE;
		cmd.wr_sel   = WR_NONE;
		cmd.head_adv = 1'b0;
		cmd.clear    = 1'b0;
		res_load     = 1'b0;
		res_hit      = 1'b0;
		res_evicted  = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				case (mode_q)
					MODE_LOOKUP: begin
						if (sts.empty) begin
							res_load = 1'b1;
						end else begin
							cmd.rd_sel = RD_HEAD;
						end
					end
					MODE_ADD: begin
						if (sts.full) begin
							cmd.rd_sel = RD_HEAD;
						end else begin
							cmd.wr_sel = WR_APPEND;
							res_load   = 1'b1;
						end
					end
					MODE_CLEAR: begin
						cmd.clear = 1'b1;
						res_load  = 1'b1;
					end
					default: begin
						res_load = 1'b1;
					end
				endcase
			end
			ST_WALK: begin
				if (sts.match) begin
					res_load = 1'b1;
					res_hit  = 1'b1;
					if (sts.cur_tail) begin
						cmd.wr_sel = WR_NONE;
					end else if (sts.cur_head) begin
						cmd.head_adv = 1'b1;
						cmd.wr_sel   = WR_TAIL_CUR;
					end else begin
						cmd.wr_sel = WR_PREV_LINK;
					end
				end else if (sts.last) begin
					res_load = 1'b1;
				end else begin
					cmd.rd_sel = RD_NEXT;
				end
			end
			ST_TAIL: begin
				cmd.wr_sel = WR_TAIL_CUR;
			end
			ST_EVICT: begin
				cmd.wr_sel  = WR_EVICT;
				res_load    = 1'b1;
				res_evicted = 1'b1;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// State, operation code and pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= '0;
			res_hit_q     <= 1'b0;
			res_evicted_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mode_q <= in_mode;
			end
			if (res_load) begin
				res_hit_q     <= res_hit;
				res_evicted_q <= res_evicted;
			end
		end
	end

	// Output register: loaded from the pending result, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			out_hit_q     <= 1'b0;
			out_evicted_q <= 1'b0;
		end else if ((state_q == ST_DONE) && slot_free) begin
			out_valid_q   <= 1'b1;
			out_hit_q     <= res_hit_q;
			out_evicted_q <= res_evicted_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// An accepted request always starts execution next cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted request not executed");

	// Finishing an operation always presents a response beat.
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && slot_free) |=> out_valid_q)
		else $error("finished operation lost its response");

	// No result reports both a hit and an eviction: hits come only from lookups, evictions only from adds.
	a_res_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !(res_hit && res_evicted))
		else $error("hit and eviction in one result");

endmodule

// ===== rtl/lru_block_number_set_top.sv =====
// Top level of the LRU block number set: controller, datapath and channels.
//
// Usage:
// The req channel carries one operation per beat: mode 0 looks up block_key
// and, on a hit, makes the oldest matching entry the newest; mode 1 appends
// block_key as newest, dropping the oldest entry when the set holds ENTRIES
// keys; mode 2 empties the set; mode 3 does nothing. Every request yields
// exactly one beat on the rsp channel with hit and evicted flags.
// Entries form a linked list in age order, kept in a key memory and a link
// memory with one read and one write port each. Clear, the idle mode and an
// add with room left finish in ST_EXEC; an add into a full set first reads
// the oldest entry's link there and evicts in ST_EVICT. A lookup walks the
// list from the oldest entry, one entry per cycle through the memory read
// port, and stops at the first match or, on a miss, at the newest entry; a
// middle entry that matches is moved to the end through ST_TAIL.
// Each result passes through ST_DONE into the output register; a new request
// can be taken in ST_DONE while the output register is loaded. Reset empties
// the set at once; no clearing pass runs.
// When rsp stalls, one response waits in the output register and the next
// request is held off only once its own result is ready.
module lru_block_number_set_top import lbns_pkg::*; #(
	parameter int ENTRIES = LBNS_ENTRIES
) (
	input logic        clk,
	input logic        arst_n,
	lbns_req_if.sink   req,
	lbns_rsp_if.source rsp
);

	lbns_cmd_t cmd;
	lbns_sts_t sts;

	// Sequencing and response register.
	lbns_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.in_mode     (req.mode),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_hit     (rsp.hit),
		.out_evicted (rsp.evicted),
		.cmd         (cmd),
		.sts         (sts)
	);

	// List storage and pointers.
	lbns_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.in_key (req.block_key),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the LRU block number set: directed table, then random episodes.
`timescale 1ns / 1ps

module testbench;
	import lbns_pkg::*;

	// The fourth operation code is unused and must leave the set untouched.
	localparam logic [MODE_W-1:0] MODE_NOOP = 2'd3;

	localparam int DIR_ROWS     = 23;
	localparam int RANDOM_ITEMS = 500;
	localparam int PRESSURE_AT  = 150;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 100;
	localparam int REPORT_MAX   = 10;

	localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
	localparam logic [KEY_W-1:0] KEY_MSB  = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic [KEY_W-1:0] KEY_LOW  = {1'b0, {(KEY_W-1){1'b1}}};

	// One row of the directed table; typed rows carry their own expectation.
	typedef struct packed {
		logic [MODE_W-1:0] op;
		logic [KEY_W-1:0]  key;
		logic              typed;
		logic              hit;
		logic              evicted;
	} dir_row_t;

	// Flags expected on one response beat.
	typedef struct packed {
		logic hit;
		logic evicted;
	} rsp_flags_t;

	logic clk;
	logic arst_n;

	lbns_req_if req ();
	lbns_rsp_if rsp ();

	lru_block_number_set_top #(
		.ENTRIES(LBNS_ENTRIES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// Block numbers in age order: index 0 is the oldest, the back is the newest.
	logic [KEY_W-1:0] age_order [$];
	rsp_flags_t       pending_flags [$];
	dir_row_t         dir_rows [0:DIR_ROWS-1];

	// Typed expectation travelling with the beat on the request channel.
	logic row_typed;
	logic row_hit;
	logic row_evicted;

	int mismatch_cnt;
	int accepted_cnt;
	int burst_left;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Reset is asserted at the start and never again.
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Applies one request to the age-ordered set and returns its flags.
	function automatic void lru_apply(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] key,
			output logic hit, output logic evicted);
		int found;
		found   = -1;
		hit     = 1'b0;
		evicted = 1'b0;
		case (op)
			MODE_LOOKUP: begin
				// The oldest matching entry wins and moves to the newest end.
				for (int i = 0; i < age_order.size() && found < 0; i++) begin
					if (age_order[i] == key)
						found = i;
				end
				if (found >= 0) begin
					age_order.delete(found);
					age_order.push_back(key);
					hit = 1'b1;
				end
			end
			MODE_ADD: begin
				if (age_order.size() >= LBNS_ENTRIES) begin
					void'(age_order.pop_front());
					evicted = 1'b1;
				end
				age_order.push_back(key);
			end
			MODE_CLEAR: begin
				age_order.delete();
			end
			default: begin
			end
		endcase
	endfunction

	// Picks a key: often one already held, sometimes a small one, else any 64-bit value.
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45 && age_order.size() != 0)
			return age_order[$urandom_range(0, age_order.size() - 1)];
		if (r < 65)
			return KEY_W'($urandom_range(0, 15));
		return {$urandom, $urandom};
	endfunction

	// Offers one beat and returns once it has been taken; idles between bursts.
	task automatic send_item(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic typed, input logic exp_hit, input logic exp_evicted);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 8);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		req.valid     <= 1'b1;
		req.mode      <= op;
		req.block_key <= key;
		row_typed     <= typed;
		row_hit       <= exp_hit;
		row_evicted   <= exp_evicted;
		@(posedge clk);
		while (req.ready !== 1'b1) @(posedge clk);
	endtask

	// Predicts on every accepted request and checks every accepted response.
	always @(posedge clk) begin
		logic       p_hit;
		logic       p_evicted;
		rsp_flags_t want;
		if (arst_n === 1'b1) begin
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				lru_apply(req.mode, req.block_key, p_hit, p_evicted);
				if (row_typed)
					pending_flags.push_back('{hit: row_hit, evicted: row_evicted});
				else
					pending_flags.push_back('{hit: p_hit, evicted: p_evicted});
				accepted_cnt++;
			end
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (pending_flags.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display("%0t: response beat with nothing expected: hit=%b evicted=%b",
							$realtime, rsp.hit, rsp.evicted);
				end else begin
					want = pending_flags.pop_front();
					if (rsp.hit !== want.hit || rsp.evicted !== want.evicted) begin
						mismatch_cnt++;
						if (mismatch_cnt <= REPORT_MAX)
							$display("%0t: mismatch: hit exp %b got %b, evicted exp %b got %b",
								$realtime, want.hit, rsp.hit, want.evicted, rsp.evicted);
					end
				end
			end
		end
	end

	// Response side: segments of varying readiness, plus one long hold-off.
	initial begin
		int  seg_left;
		int  ready_pct;
		bit  held;
		seg_left  = 0;
		ready_pct = 100;
		held      = 1'b0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && accepted_cnt >= PRESSURE_AT) begin
				// Hold off long enough for the request side to back up.
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (seg_left == 0) begin
				case ($urandom_range(0, 2))
					0: ready_pct = 100;
					1: ready_pct = 70;
					default: ready_pct = 30;
				endcase
				seg_left = $urandom_range(5, 40);
			end
			seg_left--;
			rsp.ready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	// Stimulus, drain and verdict.
	initial begin
		int               sent;
		int               episode;
		int               ep_len;
		int               add_pct;
		int               r;
		logic [KEY_W-1:0] key;
		req.valid     = 1'b0;
		req.mode      = MODE_LOOKUP;
		req.block_key = '0;
		row_typed     = 1'b0;
		row_hit       = 1'b0;
		row_evicted   = 1'b0;
		mismatch_cnt  = 0;
		accepted_cnt  = 0;
		burst_left    = 0;

		dir_rows = '{
			// Empty set after reset: lookups miss, unused code and clear do nothing.
			'{MODE_LOOKUP, '0,       1'b1, 1'b0, 1'b0},
			'{MODE_LOOKUP, KEY_ONES, 1'b1, 1'b0, 1'b0},
			'{MODE_NOOP,   KEY_ONES, 1'b1, 1'b0, 1'b0},
			'{MODE_CLEAR,  KEY_ONES, 1'b1, 1'b0, 1'b0},
			// Extreme keys go in and are found.
			'{MODE_ADD,    '0,       1'b1, 1'b0, 1'b0},
			'{MODE_ADD,    KEY_ONES, 1'b1, 1'b0, 1'b0},
			'{MODE_LOOKUP, '0,       1'b1, 1'b1, 1'b0},
			'{MODE_LOOKUP, KEY_ONES, 1'b1, 1'b1, 1'b0},
			// A duplicate key: only the oldest copy is promoted on lookup.
			'{MODE_ADD,    '0,                    1'b0, 1'b0, 1'b0},
			'{MODE_ADD,    64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0},
			'{MODE_ADD,    64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0},
			'{MODE_LOOKUP, '0,                    1'b0, 1'b0, 1'b0},
			'{MODE_LOOKUP, '0,                    1'b0, 1'b0, 1'b0},
			'{MODE_LOOKUP, 64'h1,                 1'b0, 1'b0, 1'b0},
			'{MODE_LOOKUP, KEY_MSB,               1'b0, 1'b0, 1'b0},
			'{MODE_NOOP,   '0,                    1'b1, 1'b0, 1'b0},
			'{MODE_ADD,    KEY_MSB,               1'b0, 1'b0, 1'b0},
			'{MODE_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0},
			// Clear empties everything; old keys no longer hit.
			'{MODE_CLEAR,  '0,       1'b1, 1'b0, 1'b0},
			'{MODE_LOOKUP, '0,       1'b1, 1'b0, 1'b0},
			'{MODE_LOOKUP, KEY_ONES, 1'b1, 1'b0, 1'b0},
			'{MODE_ADD,    KEY_LOW,  1'b1, 1'b0, 1'b0},
			'{MODE_LOOKUP, KEY_LOW,  1'b1, 1'b1, 1'b0}
		};

		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed table.
		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed,
				dir_rows[i].hit, dir_rows[i].evicted);

		// Random episodes; the first is add-heavy so the set fills and evicts early.
		sent    = 0;
		episode = 0;
		while (sent < RANDOM_ITEMS) begin
			ep_len  = (episode == 0) ? 150 : $urandom_range(10, 160);
			add_pct = (episode == 0) ? 75 : $urandom_range(35, 65);
			if (episode != 0) begin
				send_item(MODE_CLEAR, {$urandom, $urandom}, 1'b0, 1'b0, 1'b0);
				sent++;
			end
			for (int i = 0; i < ep_len && sent < RANDOM_ITEMS; i++) begin
				r   = $urandom_range(0, 99);
				key = pick_key();
				if (r < 2)
					send_item(MODE_NOOP, key, 1'b0, 1'b0, 1'b0);
				else if (r == 99)
					send_item(MODE_CLEAR, key, 1'b0, 1'b0, 1'b0);
				else if (r < 2 + add_pct)
					send_item(MODE_ADD, key, 1'b0, 1'b0, 1'b0);
				else
					send_item(MODE_LOOKUP, key, 1'b0, 1'b0, 1'b0);
				sent++;
			end
			episode++;
		end
		req.valid <= 1'b0;

		// Wait for the last responses, then give stray beats a chance to show up.
		@(posedge clk);
		while (pending_flags.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0 && pending_flags.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lbns_pkg.sv
rtl/lbns_req_if.sv
rtl/lbns_rsp_if.sv
rtl/lbns_ram.sv
rtl/lbns_dpath.sv
rtl/lbns_ctrl.sv
rtl/lru_block_number_set_top.sv
dv/testbench.sv
